### src/spgl_pkg.sv
`timescale 1ns / 1ps
// Package for the sample player gain limiter: command codes, register
// indexes and the sizes shared by the interfaces and the top level.
package spgl_pkg;

   localparam int AddrBits  = 16;
   localparam int GainBits  = 16;
   localparam int DutyBits  = 16;
   localparam int CountBits = 17;
   localparam int CsrIdxBits  = 3;
   localparam int CsrDataBits = 17;

   localparam logic [CountBits-1:0] SampleCountReset = CountBits'(65536);
   localparam logic [DutyBits-1:0]  PwmTopReset      = DutyBits'(255);
   localparam logic [GainBits-1:0]  StartGainReset   = GainBits'(2560);
   localparam logic [GainBits-1:0]  GainStepReset    = GainBits'(26);

   typedef enum logic [2:0] {
      FUNC_TICK      = 3'd0,
      FUNC_GAIN_UP   = 3'd1,
      FUNC_GAIN_DOWN = 3'd2,
      FUNC_START     = 3'd3,
      FUNC_STOP      = 3'd4
   } func_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_SAMPLE_COUNT = 3'd0,
      CSR_LOOP_ENABLE  = 3'd1,
      CSR_PWM_TOP      = 3'd2,
      CSR_START_GAIN   = 3'd3,
      CSR_GAIN_STEP    = 3'd4
   } csr_index_type;

endpackage

### src/spgl_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample player gain limiter:
// command items, result items and register writes. Uses spgl_pkg.
interface spgl_req_if import spgl_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] sample;
   modport source (output valid, func, sample, input ready);
   modport sink   (input valid, func, sample, output ready);
endinterface

interface spgl_rsp_if import spgl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DutyBits-1:0] duty;
   logic [15:0]         read_address;
   logic                playing;
   logic                clipped;
   logic [GainBits-1:0] gain_now;
   modport source (output valid, duty, read_address, playing, clipped, gain_now,
                   input ready);
   modport sink   (input valid, duty, read_address, playing, clipped, gain_now,
                   output ready);
endinterface

interface spgl_csr_if import spgl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CsrIdxBits-1:0]  index;
   logic [CsrDataBits-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/sample_player_gain_limiter.sv
`timescale 1ns / 1ps
// Sample player with PWM duty output and automatic gain limiter.
// Uses spgl_pkg and the channel interfaces in spgl_if.sv.
//
// Usage:
//   req carries one command item: func (tick, gain up, gain down, start,
//   stop) and the 8-bit unsigned sample at the current read address.
//   rsp returns exactly one result item per command: duty, read_address,
//   playing, clipped and the gain after the command.
//   csr writes the five registers (sample_count, loop_enable, pwm_top,
//   start_gain, gain_step) by index; write only while no item is in flight.
// Datapath and throughput:
//   The whole command is computed in one pass from the incoming item and
//   the held state, and the result lands in the output register on the
//   accepting edge; one item per cycle is sustained while rsp.ready is high.
//   The path is one 10x17 signed multiply, a rounding shift, a clamp and a
//   divide by 127 done as two fold-and-add steps and one compare.
// Reset:
//   Synchronous, active high. Gain goes to 10.0, position and duty to zero,
//   playback stops, registers take their defaults; both req and csr hold
//   ready low while reset is high.
// Stalls:
//   A result waits in the output register while rsp.ready is low; req stays
//   ready when the output register is empty or being drained in the same
//   cycle, so a stalled receiver backs up the sender by exactly one item.
module sample_player_gain_limiter
   import spgl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   spgl_req_if.sink   req,
   spgl_rsp_if.source rsp,
   spgl_csr_if.sink   csr
);

   // configuration registers
   logic [CountBits-1:0] sample_count_ff;
   logic                 loop_enable_ff;
   logic [DutyBits-1:0]  pwm_top_ff;
   logic [GainBits-1:0]  start_gain_ff;
   logic [GainBits-1:0]  gain_step_ff;

   // player state
   logic [GainBits-1:0] gain_ff, gain_in;
   logic [AddrBits-1:0] position_ff, position_in;
   logic                active_ff, active_in;
   logic [DutyBits-1:0] last_duty_ff, last_duty_in;

   // output register
   logic       rsp_valid_ff;
   logic       rsp_clipped_ff, clip_in;

   logic req_take;
   logic csr_take;
   func_type func;

   // tick datapath
   logic signed [9:0]  centered;
   logic signed [26:0] prod;
   logic signed [26:0] prod_adj;
   logic signed [17:0] scaled;
   logic signed [17:0] level;
   logic               under;
   logic               over;
   logic [15:0]        overshoot;
   logic [16:0]        dbl;
   logic [10:0]        fold1;
   logic [7:0]         fold2;
   logic [9:0]         quot;
   logic [17:0]        dec;
   logic [GainBits-1:0] gain_dropped;
   logic [AddrBits-1:0] end_pos;
   logic [GainBits:0]   gain_sum;

   assign req_take = req.valid && req.ready;
   assign csr_take = csr.valid && csr.ready;
   assign func     = func_type'(req.func);

   // Take a new item when the output slot is free or drains this cycle.
   assign req.ready = !reset && (!rsp_valid_ff || rsp.ready);
   assign csr.ready = !reset;

   // Scale: (sample - 127) * gain, divided by 256 toward zero, recentred.
   assign centered = $signed(10'({2'b00, req.sample})) - 10'sd127;
   assign prod     = 27'(centered) * $signed(27'({1'b0, gain_ff}));
   assign prod_adj = prod + (prod < 0 ? 27'sd255 : 27'sd0);
   assign scaled   = 18'(prod_adj >>> 8);
   assign level    = scaled + 18'sd127;
   assign under    = level < 0;
   assign over     = !under && (level > $signed({2'b00, pwm_top_ff}));

   assign overshoot = under ? 16'(-level)
                            : 16'(level - $signed({2'b00, pwm_top_ff}));

   // overshoot*256/127 = 2*o + floor(2*o/127); fold 2*o by 128 = 127 + 1
   assign dbl   = {overshoot, 1'b0};
   assign fold1 = 11'(dbl[6:0]) + 11'(dbl[16:7]);
   assign fold2 = 8'(fold1[6:0]) + 8'(fold1[10:7]);
   assign quot  = 10'(dbl[16:7]) + 10'(fold1[10:7]) + 10'(fold2 >= 8'd127);
   assign dec   = 18'(dbl) + 18'(quot);
   assign gain_dropped = (dec >= 18'(gain_ff)) ? '0 : GainBits'(18'(gain_ff) - dec);

   assign end_pos  = AddrBits'(sample_count_ff - CountBits'(1));
   assign gain_sum = (GainBits+1)'(gain_ff) + (GainBits+1)'(gain_step_ff);

   always_comb begin
      gain_in      = gain_ff;
      position_in  = position_ff;
      active_in    = active_ff;
      last_duty_in = last_duty_ff;
      clip_in      = 1'b0;
      unique case (func)
         FUNC_TICK: begin
            if (active_ff) begin
               if (under) begin
                  clip_in      = 1'b1;
                  gain_in      = gain_dropped;
                  last_duty_in = '0;
               end else if (over) begin
                  clip_in      = 1'b1;
                  gain_in      = gain_dropped;
                  last_duty_in = pwm_top_ff;
               end else begin
                  last_duty_in = DutyBits'(level);
               end
               // advance; hold on the last sample when not looping
               if (position_ff == end_pos) begin
                  if (loop_enable_ff) begin
                     position_in = '0;
                  end else begin
                     active_in    = 1'b0;
                     last_duty_in = '0;
                  end
               end else begin
                  position_in = position_ff + AddrBits'(1);
               end
            end
         end
         FUNC_GAIN_UP: begin
            gain_in = gain_sum[GainBits] ? '1 : gain_sum[GainBits-1:0];
         end
         FUNC_GAIN_DOWN: begin
            gain_in = (gain_step_ff >= gain_ff) ? '0 : gain_ff - gain_step_ff;
         end
         FUNC_START: begin
            gain_in     = start_gain_ff;
            position_in = '0;
            active_in   = 1'b1;
         end
         FUNC_STOP: begin
            active_in    = 1'b0;
            last_duty_in = '0;
         end
         default: begin
            // unused codes leave the state alone
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SampleCountReset;
         loop_enable_ff  <= 1'b0;
         pwm_top_ff      <= PwmTopReset;
         start_gain_ff   <= StartGainReset;
         gain_step_ff    <= GainStepReset;
      end else if (csr_take) begin
         unique case (csr_index_type'(csr.index))
            CSR_SAMPLE_COUNT: sample_count_ff <= csr.data;
            CSR_LOOP_ENABLE:  loop_enable_ff  <= csr.data[0];
            CSR_PWM_TOP:      pwm_top_ff      <= csr.data[DutyBits-1:0];
            CSR_START_GAIN:   start_gain_ff   <= csr.data[GainBits-1:0];
            CSR_GAIN_STEP:    gain_step_ff    <= csr.data[GainBits-1:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   // State and the output register advance together on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= StartGainReset;
         position_ff  <= '0;
         active_ff    <= 1'b0;
         last_duty_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            gain_ff      <= gain_in;
            position_ff  <= position_in;
            active_ff    <= active_in;
            last_duty_ff <= last_duty_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_clipped_ff <= clip_in;
      end
   end

   // The state registers already hold the result of the last item.
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.duty         = last_duty_ff;
   assign rsp.read_address = 16'(position_ff);
   assign rsp.playing      = active_ff;
   assign rsp.clipped      = rsp_clipped_ff;
   assign rsp.gain_now     = gain_ff;

endmodule

### src/spgl_checker.sv
`timescale 1ns / 1ps
// Port-level checker for sample_player_gain_limiter and its bind.
// Uses spgl_pkg for the command codes.
module spgl_checker
   import spgl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_duty,
   input logic        rsp_playing,
   input logic        rsp_clipped
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_stop: assert property (@(posedge clock) disable iff (reset)
      req_take && req_func == FUNC_STOP |=> rsp_valid && !rsp_playing && rsp_duty == 16'd0)
      else $error("stop did not silence the output");

   a_no_clip: assert property (@(posedge clock) disable iff (reset)
      req_take && req_func != FUNC_TICK |=> !rsp_clipped)
      else $error("clip flagged on a non-tick item");

   a_idle_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_playing |-> rsp_duty == 16'd0)
      else $error("nonzero duty while stopped");

   a_start: assert property (@(posedge clock) disable iff (reset)
      req_take && req_func == FUNC_START |=> rsp_valid && rsp_playing)
      else $error("start did not begin playback");

endmodule

bind sample_player_gain_limiter spgl_checker u_spgl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .req_func    (req.func),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_duty    (rsp.duty),
   .rsp_playing (rsp.playing),
   .rsp_clipped (rsp.clipped)
);

### tb/spgl_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the sample player gain limiter: watches the command, result
// and register channels, predicts every result item and compares it field by field.
// Depends on spgl_pkg and the channel interfaces of spgl_if.sv.
module spgl_result_checker
   import spgl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   spgl_req_if         req,
   spgl_rsp_if         rsp,
   spgl_csr_if         csr,
   output int unsigned error_count,
   output int unsigned in_flight,
   output int unsigned live_items
);

   typedef struct packed {
      logic [DutyBits-1:0] duty;
      logic [15:0]         addr;
      logic                playing;
      logic                clipped;
      logic [GainBits-1:0] gain;
   } result_t;

   result_t predicted_results[$];

   // register copies
   logic [CountBits-1:0] cfg_count;
   logic                 cfg_loop;
   logic [DutyBits-1:0]  cfg_top;
   logic [GainBits-1:0]  cfg_start_gain;
   logic [GainBits-1:0]  cfg_step;

   // player state
   logic [GainBits-1:0]  gain_q8;
   logic [AddrBits-1:0]  position;
   logic                 active;
   logic [DutyBits-1:0]  last_duty;

   int unsigned mismatches = 0;
   int unsigned results_seen = 0;

   assign error_count = mismatches;

   task automatic report(input string field, input logic [31:0] got,
                         input logic [31:0] want);
      mismatches++;
      if (mismatches <= 30)
         $display("[%0t] result %0d: %s got %0d, expected %0d",
                  $realtime, results_seen, field, got, want);
   endtask

   // Lower the gain by overshoot*256/127, floored at zero.
   function automatic logic [GainBits-1:0] limit_gain(input logic [GainBits-1:0] g,
                                                      input int unsigned over);
      int unsigned cut;
      cut = over * 256 / 127;
      return (cut >= g) ? '0 : GainBits'(g - cut);
   endfunction

   function automatic result_t play_command(input logic [2:0] func, input logic [7:0] smp);
      int prod;
      int level;
      logic clip;
      logic [AddrBits-1:0] last_addr;
      clip = 1'b0;
      case (func)
         FUNC_TICK: begin
            if (active) begin
               prod  = (int'(smp) - 127) * int'(gain_q8);
               level = prod / 256 + 127;
               if (level < 0) begin
                  clip      = 1'b1;
                  gain_q8   = limit_gain(gain_q8, -level);
                  last_duty = '0;
               end else if (level > int'(cfg_top)) begin
                  clip      = 1'b1;
                  gain_q8   = limit_gain(gain_q8, level - int'(cfg_top));
                  last_duty = cfg_top;
               end else begin
                  last_duty = level[DutyBits-1:0];
               end
               // end address wraps within the address width
               last_addr = AddrBits'(cfg_count - 1'b1);
               if (position == last_addr) begin
                  if (cfg_loop) begin
                     position = '0;
                  end else begin
                     active    = 1'b0;
                     last_duty = '0;
                  end
               end else begin
                  position = position + 1'b1;
               end
            end
         end
         FUNC_GAIN_UP: begin
            gain_q8 = (int'(gain_q8) + int'(cfg_step) > 65535) ? '1 : gain_q8 + cfg_step;
         end
         FUNC_GAIN_DOWN: begin
            gain_q8 = (cfg_step >= gain_q8) ? '0 : gain_q8 - cfg_step;
         end
         FUNC_START: begin
            gain_q8  = cfg_start_gain;
            position = '0;
            active   = 1'b1;
         end
         FUNC_STOP: begin
            active    = 1'b0;
            last_duty = '0;
         end
         default: ;
      endcase
      return '{duty: last_duty, addr: position, playing: active, clipped: clip,
               gain: gain_q8};
   endfunction

   always @(posedge clock) begin
      result_t got;
      result_t want;
      if (reset) begin
         cfg_count      = SampleCountReset;
         cfg_loop       = 1'b0;
         cfg_top        = PwmTopReset;
         cfg_start_gain = StartGainReset;
         cfg_step       = GainStepReset;
         gain_q8        = StartGainReset;
         position       = '0;
         active         = 1'b0;
         last_duty      = '0;
         predicted_results.delete();
         in_flight  <= 0;
         live_items <= 0;
      end else begin
         // check results first so an item taken on this edge never matches
         if (rsp.valid && rsp.ready) begin
            got = '{duty: rsp.duty, addr: rsp.read_address, playing: rsp.playing,
                    clipped: rsp.clipped, gain: rsp.gain_now};
            if (predicted_results.size() == 0) begin
               report("unexpected result", 0, 0);
            end else begin
               want = predicted_results.pop_front();
               if (got.duty !== want.duty)       report("duty", got.duty, want.duty);
               if (got.addr !== want.addr)       report("read_address", got.addr, want.addr);
               if (got.playing !== want.playing) report("playing", got.playing, want.playing);
               if (got.clipped !== want.clipped) report("clipped", got.clipped, want.clipped);
               if (got.gain !== want.gain)       report("gain_now", got.gain, want.gain);
            end
            results_seen++;
         end
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_SAMPLE_COUNT: cfg_count      = csr.data;
               CSR_LOOP_ENABLE:  cfg_loop       = csr.data[0];
               CSR_PWM_TOP:      cfg_top        = csr.data[DutyBits-1:0];
               CSR_START_GAIN:   cfg_start_gain = csr.data[GainBits-1:0];
               CSR_GAIN_STEP:    cfg_step       = csr.data[GainBits-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            live_items <= live_items + 1;
            predicted_results.push_back(play_command(req.func, req.sample));
         end
         in_flight <= predicted_results.size();
      end
   end

endmodule

### tb/tb_sample_player_gain_limiter.sv
`timescale 1ns / 1ps
// Testbench top for the sample player gain limiter: clock, reset, command and
// register stimulus, receiver stalls and the verdict. Uses spgl_pkg, the channel
// interfaces and spgl_result_checker.
module tb_sample_player_gain_limiter
   import spgl_pkg::*;
();

   localparam int unsigned LiveItemTarget = 1850;
   localparam int unsigned CycleLimit     = 400000;

   logic clock = 1'b0;
   logic reset;

   spgl_req_if req_bus ();
   spgl_rsp_if rsp_bus ();
   spgl_csr_if csr_bus ();

   int unsigned error_count;
   int unsigned in_flight;
   int unsigned live_items;

   sample_player_gain_limiter uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   spgl_result_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr         (csr_bus),
      .error_count (error_count),
      .in_flight   (in_flight),
      .live_items  (live_items)
   );

   always #4 clock = ~clock;

   // Give up well past the slowest legal run.
   int unsigned cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: switch between always-ready, coin-flip and mostly-stalled
   // stretches. Twice, while the sender is offering, hold off for a long
   // stretch so the output register fills and the command channel backs up.
   int unsigned taken = 0;
   int unsigned hold_left = 0;
   int unsigned holds_done = 0;
   int unsigned next_hold_at = 400;
   int unsigned stall_mode = 0;
   int unsigned mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (holds_done < 2 && taken >= next_hold_at && req_bus.valid) begin
            hold_left = 300;
            holds_done++;
            next_hold_at += 900;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(10, 120);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Sender: items go out in bursts; a burst ends with valid low for a random gap.
   int unsigned burst_left = 0;

   task automatic send(input logic [2:0] f, input logic [7:0] s);
      req_bus.valid  <= 1'b1;
      req_bus.func   <= f;
      req_bus.sample <= s;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 15);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataBits-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and hold until every predicted result has come back, then
   // pad the wait with idle clocks before the next phase.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_random_settings();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      write_reg(CSR_SAMPLE_COUNT,
                (pick == 0) ? 17'd0 :
                (pick == 1) ? 17'd1 :
                (pick == 2) ? 17'd65536 :
                (pick == 3) ? 17'($urandom_range(0, 131071)) :
                (pick <= 6) ? 17'($urandom_range(2, 8)) : 17'($urandom_range(9, 64)));
      write_reg(CSR_LOOP_ENABLE, 17'($urandom_range(0, 1)));
      pick = $urandom_range(0, 9);
      write_reg(CSR_PWM_TOP,
                (pick == 0) ? 17'd0 :
                (pick == 1) ? 17'd65535 :
                (pick == 2) ? 17'($urandom_range(0, 65535)) :
                (pick <= 5) ? 17'd255 : 17'($urandom_range(1, 300)));
      pick = $urandom_range(0, 9);
      write_reg(CSR_START_GAIN,
                (pick == 0) ? 17'd0 :
                (pick == 1) ? 17'd65535 :
                (pick == 2) ? 17'($urandom_range(0, 65535)) :
                (pick == 3) ? 17'd256 : 17'($urandom_range(0, 1024)));
      pick = $urandom_range(0, 9);
      write_reg(CSR_GAIN_STEP,
                (pick == 0) ? 17'd0 :
                (pick == 1) ? 17'd65535 :
                (pick == 2) ? 17'($urandom_range(0, 65535)) : 17'($urandom_range(0, 100)));
   endtask

   // Mostly ticks of a running clip, with gain steps, restarts, stops and
   // the odd unused code mixed in.
   task automatic send_random_command();
      int unsigned pick;
      logic [2:0] f;
      logic [7:0] s;
      pick = $urandom_range(0, 99);
      if (pick < 62)      f = FUNC_TICK;
      else if (pick < 70) f = FUNC_GAIN_UP;
      else if (pick < 77) f = FUNC_GAIN_DOWN;
      else if (pick < 86) f = FUNC_START;
      else if (pick < 91) f = FUNC_STOP;
      else                f = 3'($urandom_range(int'(FUNC_STOP) + 1, 7));
      pick = $urandom_range(0, 9);
      if (pick == 0)      s = 8'd0;
      else if (pick == 1) s = 8'd255;
      else if (pick == 2) s = 8'($urandom_range(120, 135));
      else                s = 8'($urandom_range(0, 255));
      send(f, s);
   endtask

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.func   <= FUNC_TICK;
      req_bus.sample <= '0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= CSR_SAMPLE_COUNT;
      csr_bus.data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: ignored items, gain steps, a start, a clip at the top,
      // a stop and a tick after it.
      send(FUNC_TICK, 8'd0);
      send(3'd7, 8'd255);
      send(3'd5, 8'd0);
      send(FUNC_GAIN_UP, 8'd0);
      send(FUNC_GAIN_DOWN, 8'd0);
      send(FUNC_START, 8'd0);
      send(FUNC_TICK, 8'd255);
      send(FUNC_TICK, 8'd0);
      send(FUNC_TICK, 8'd127);
      send(FUNC_TICK, 8'd128);
      send(FUNC_STOP, 8'd0);
      send(FUNC_TICK, 8'd200);
      wait_idle();

      // Top extremes: saturate the gain, drive the widest products, then
      // play off the end of a short clip without looping.
      write_reg(CSR_SAMPLE_COUNT, 17'd3);
      write_reg(CSR_LOOP_ENABLE, 17'd0);
      write_reg(CSR_PWM_TOP, 17'd65535);
      write_reg(CSR_START_GAIN, 17'd65535);
      write_reg(CSR_GAIN_STEP, 17'd65535);
      send(FUNC_START, 8'd0);
      send(FUNC_GAIN_UP, 8'd0);
      send(FUNC_TICK, 8'd255);
      send(FUNC_TICK, 8'd0);
      send(FUNC_GAIN_DOWN, 8'd0);
      send(FUNC_TICK, 8'd128);
      send(FUNC_TICK, 8'd10);
      send(FUNC_START, 8'd0);
      wait_idle();

      // Bottom extremes: restart while playing, zero duty ceiling, looping
      // two-sample clip and a zero gain step.
      write_reg(CSR_SAMPLE_COUNT, 17'd2);
      write_reg(CSR_LOOP_ENABLE, 17'd1);
      write_reg(CSR_PWM_TOP, 17'd0);
      write_reg(CSR_START_GAIN, 17'd256);
      write_reg(CSR_GAIN_STEP, 17'd0);
      send(FUNC_START, 8'd0);
      send(FUNC_TICK, 8'd127);
      send(FUNC_TICK, 8'd50);
      send(FUNC_TICK, 8'd255);
      send(FUNC_GAIN_UP, 8'd0);
      wait_idle();

      // Random phases, each with fresh settings written while idle.
      while (live_items < LiveItemTarget) begin
         load_random_settings();
         repeat ($urandom_range(100, 250)) send_random_command();
         wait_idle();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
src/spgl_pkg.sv
src/spgl_if.sv
src/sample_player_gain_limiter.sv
src/spgl_checker.sv
tb/spgl_result_checker.sv
tb/tb_sample_player_gain_limiter.sv
